[rtl/msb_first_bit_field_reader_macros.svh]
// ----------------------------------------------------------------------------
// msb_first_bit_field_reader assertion macros
// Shared concurrent assertion forms for the bit field reader checks.
// ----------------------------------------------------------------------------
`ifndef MSB_FIRST_BIT_FIELD_READER_MACROS_SVH
`define MSB_FIRST_BIT_FIELD_READER_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define MBFR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define MBFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mbfr_pkg.sv]
// ----------------------------------------------------------------------------
// mbfr_pkg
// Types and constants shared by the MSB-first bit field reader.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbfr_pkg;

    // default sizing
    localparam int BUFFER_BYTES_DEF   = 4096;
    localparam int MAX_FIELD_BITS_DEF = 32;

    // fixed field widths
    localparam int FUNC_W    = 2;
    localparam int BADDR_W   = 12;
    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 6;
    localparam int SIZE_W    = 13;
    localparam int POS_W     = 16;
    localparam int FIELD_W   = 32;
    localparam int IDX_W     = 17;
    localparam int BITOFF_W  = 3;

    // item function codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE     = 2'd0,
        FUNC_READ      = 2'd1,
        FUNC_RESET_POS = 2'd2
    } t_func;

    // sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_FETCH
    } t_state;

endpackage

[rtl/mbfr_byte_ram.sv]
// ----------------------------------------------------------------------------
// mbfr_byte_ram
// Simple dual-port byte memory, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbfr_byte_ram
    import mbfr_pkg::*;
#(
    parameter int DEPTH  = BUFFER_BYTES_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [BYTE_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/msb_first_bit_field_reader.sv]
// ----------------------------------------------------------------------------
// msb_first_bit_field_reader
// Byte buffer with a running bit position; reads fields MSB first.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 beat
//  item      in         start & !busy             func, byte addr/data, bit count
//  result    out        o_done (one-cycle strobe) field value, read ok, bit position
//  config    in         i_cfg_valid & o_cfg_ready buffer size
//
//  Write, position reset, unused code, refused read: result in the next cycle.
//  Accepted read: n = ceil((bit offset + count) / 8) byte fetches, one a cycle
//  on the single memory read port, then the field is aligned, masked and strobed;
//  no fetch when no byte is spanned (zero count on a byte boundary).
//  Reset clears position and buffer size; buffer contents are not cleared.
//  The receiver cannot stall; busy holds off items until a read completes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msb_first_bit_field_reader
    import mbfr_pkg::*;
#(
    parameter int BUFFER_BYTES   = BUFFER_BYTES_DEF,
    parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [BADDR_W-1:0]  i_byte_addr,
    input  logic [BYTE_W-1:0]   i_byte_data,
    input  logic [COUNT_W-1:0]  i_bit_count,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [SIZE_W-1:0]   i_cfg_data,
    output logic                o_done,
    output logic [FIELD_W-1:0]  o_field_value,
    output logic                o_read_ok,
    output logic [POS_W-1:0]    o_bit_position
);

    localparam int ADDR_W = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam int FW     = MAX_FIELD_BITS;
    localparam int CSAT_W = $clog2(MAX_FIELD_BITS + 1);
    localparam int SUM_W  = $clog2(MAX_FIELD_BITS + 15);
    localparam int NB_MAX = (MAX_FIELD_BITS + 14) / 8;
    localparam int NB_W   = $clog2(NB_MAX + 1);
    localparam int ACC_W  = MAX_FIELD_BITS + 14;

    t_state               r_state, n_state;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic [SIZE_W-1:0]    r_size, n_size;
    logic [IDX_W-1:0]     r_addr, n_addr;
    logic [NB_W-1:0]      r_left, n_left;
    logic                 r_rd_vld, n_rd_vld;
    logic                 r_rd_inr, n_rd_inr;
    logic [ACC_W-1:0]     r_acc, n_acc;
    logic [BITOFF_W-1:0]  r_tail, n_tail;
    logic [CSAT_W-1:0]    r_cnt, n_cnt;
    logic [FW-1:0]        r_field, n_field;
    logic                 r_ok, n_ok;
    logic                 r_done, n_done;

    logic                 accept;
    logic                 cfg_wr;
    logic [IDX_W-1:0]     eff_size;
    logic [IDX_W-1:0]     pos_byte;
    logic [IDX_W-1:0]     pos_ceil;
    logic                 read_ok;
    logic [CSAT_W-1:0]    cnt_sat;
    logic [SUM_W-1:0]     off_cnt;
    logic [NB_W-1:0]      nb;
    logic                 wr_en;
    logic                 rd_en;
    logic                 rd_inr;
    logic [BYTE_W-1:0]    rd_data;
    logic [ACC_W-1:0]     acc_shift;
    logic [FW-1:0]        field_mask;
    logic [FW-1:0]        field_fin;
    logic [63:0]          field_ext;

    assign accept      = start && !busy;
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // buffer size clipped to the memory depth
    assign eff_size = (32'(r_size) < BUFFER_BYTES) ? IDX_W'(r_size) : IDX_W'(BUFFER_BYTES);

    // refuse check on the byte-rounded position
    assign pos_byte = IDX_W'(r_pos[POS_W-1:BITOFF_W]);
    assign pos_ceil = pos_byte + IDX_W'(r_pos[BITOFF_W-1:0] != '0);
    assign read_ok  = (pos_ceil < eff_size);

    // saturated count, bytes spanned and final alignment
    assign cnt_sat = (int'(i_bit_count) > MAX_FIELD_BITS) ? CSAT_W'(MAX_FIELD_BITS)
                                                          : CSAT_W'(i_bit_count);
    assign off_cnt = SUM_W'(r_pos[BITOFF_W-1:0]) + SUM_W'(cnt_sat);
    assign nb      = NB_W'((off_cnt + SUM_W'(7)) >> 3);

    // byte fetch issue
    assign rd_en  = (r_state == ST_FETCH) && (r_left != '0);
    assign rd_inr = (r_addr < eff_size);
    assign wr_en  = accept && (i_func == FUNC_WRITE) && (32'(i_byte_addr) < BUFFER_BYTES);

    mbfr_byte_ram #(
        .DEPTH  (BUFFER_BYTES),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (ADDR_W'(i_byte_addr)),
        .i_wdata (i_byte_data),
        .i_re    (rd_en),
        .i_raddr (r_addr[ADDR_W-1:0]),
        .o_rdata (rd_data)
    );

    // final alignment and mask of the collected bytes
    assign acc_shift  = r_acc >> r_tail;
    assign field_mask = ~({FW{1'b1}} << r_cnt);
    assign field_fin  = acc_shift[FW-1:0] & field_mask;

    // next state and datapath
    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_size   = r_size;
        n_addr   = r_addr;
        n_left   = r_left;
        n_rd_vld = rd_en;
        n_rd_inr = rd_inr;
        n_acc    = r_acc;
        n_tail   = r_tail;
        n_cnt    = r_cnt;
        n_field  = r_field;
        n_ok     = r_ok;
        n_done   = 1'b0;

        if (cfg_wr) begin
            n_size = i_cfg_data;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_field = '0;
                    n_ok    = 1'b0;
                    unique case (i_func)
                        FUNC_READ: begin
                            if (read_ok) begin
                                n_pos   = r_pos + POS_W'(cnt_sat);
                                n_addr  = pos_byte;
                                n_left  = nb;
                                n_acc   = '0;
                                n_cnt   = cnt_sat;
                                n_tail  = BITOFF_W'(BITOFF_W'(0) - off_cnt[BITOFF_W-1:0]);
                                n_state = ST_FETCH;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        FUNC_RESET_POS: begin
                            n_pos  = '0;
                            n_done = 1'b1;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                // issue one byte address a cycle
                if (rd_en) begin
                    n_addr = r_addr + IDX_W'(1);
                    n_left = r_left - NB_W'(1);
                end
                // shift in the returned byte, zero past the buffer end
                if (r_rd_vld) begin
                    n_acc = {r_acc[ACC_W-BYTE_W-1:0], (r_rd_inr ? rd_data : BYTE_W'(0))};
                end
                // all bytes in: align and present
                if (!rd_en && !r_rd_vld) begin
                    n_field = field_fin;
                    n_ok    = 1'b1;
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_size   <= '0;
            r_left   <= '0;
            r_rd_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_size   <= n_size;
            r_left   <= n_left;
            r_rd_vld <= n_rd_vld;
            r_done   <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_rd_inr <= n_rd_inr;
        r_acc    <= n_acc;
        r_tail   <= n_tail;
        r_cnt    <= n_cnt;
        r_field  <= n_field;
        r_ok     <= n_ok;
    end

    // result ports, low 32 bits of the field
    assign field_ext      = 64'(r_field);
    assign o_field_value  = field_ext[FIELD_W-1:0];
    assign o_read_ok      = r_ok;
    assign o_bit_position = r_pos;
    assign o_done         = r_done;

endmodule

[rtl/mbfr_checker.sv]
// ----------------------------------------------------------------------------
// mbfr_checker
// Port-level checks of the bit field reader, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "msb_first_bit_field_reader_macros.svh"

module mbfr_checker
    import mbfr_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic [FUNC_W-1:0]   i_func,
    input logic                i_cfg_valid,
    input logic                o_cfg_ready,
    input logic                o_done,
    input logic [FIELD_W-1:0]  o_field_value,
    input logic                o_read_ok,
    input logic [POS_W-1:0]    o_bit_position
);

    // items other than reads answer in the next cycle
    `MBFR_ASSERT_NEXT(a_nonread_done, i_clk, i_rst_n, start && !busy && (i_func != FUNC_READ), o_done, "non-read item gave no result in the next cycle")

    // refused or non-read beats carry a zero field
    `MBFR_ASSERT_SAME(a_refused_zero, i_clk, i_rst_n, o_done && !o_read_ok, o_field_value == '0, "field not zero without a performed read")

    // a position reset shows position zero with its result
    `MBFR_ASSERT_NEXT(a_reset_pos, i_clk, i_rst_n, start && !busy && (i_func == FUNC_RESET_POS), o_done && (o_bit_position == '0) && !o_read_ok, "position reset not reflected")

    // the position only moves when an item is taken
    `MBFR_ASSERT_NEXT(a_pos_hold, i_clk, i_rst_n, !(start && !busy), $stable(o_bit_position), "bit position moved without an item")

    // configuration beats only land while no read is in progress
    `MBFR_ASSERT_SAME(a_cfg_idle, i_clk, i_rst_n, i_cfg_valid && o_cfg_ready, !busy, "configuration taken while a read is in progress")

endmodule

bind msb_first_bit_field_reader mbfr_checker u_mbfr_checker (.*);

[bench/msb_first_bit_field_reader_test.sv]
// ----------------------------------------------------------------------------
// msb_first_bit_field_reader_test
// Self-checking bench for the MSB-first bit field reader. A queue of byte
// writes, field reads, position resets and unused codes feeds a driver that
// sends in bursts with random gaps. A monitor predicts each result when its
// item is accepted and compares every strobed result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msb_first_bit_field_reader_test;
    import mbfr_pkg::*;

    localparam int STORE_BYTES   = BUFFER_BYTES_DEF;
    localparam int MAX_BITS      = MAX_FIELD_BITS_DEF;
    localparam int BITS_PER_BYTE = 8;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_OPS     = 76;
    localparam int SWEEP_READS   = 24;
    localparam int PRELOAD_BYTES = 128;

    // code that the block ignores
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [BADDR_W-1:0] addr;
        logic [BYTE_W-1:0]  data;
        logic [COUNT_W-1:0] count;
    } t_field_op;

    typedef struct packed {
        logic [FIELD_W-1:0] value;
        logic               ok;
        logic [POS_W-1:0]   pos;
    } t_field_result;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               start       = 1'b0;
    logic               busy;
    logic [FUNC_W-1:0]  i_func      = '0;
    logic [BADDR_W-1:0] i_byte_addr = '0;
    logic [BYTE_W-1:0]  i_byte_data = '0;
    logic [COUNT_W-1:0] i_bit_count = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [SIZE_W-1:0]  i_cfg_data  = '0;
    logic               o_done;
    logic [FIELD_W-1:0] o_field_value;
    logic               o_read_ok;
    logic [POS_W-1:0]   o_bit_position;

    msb_first_bit_field_reader dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_byte_addr    (i_byte_addr),
        .i_byte_data    (i_byte_data),
        .i_bit_count    (i_bit_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_done         (o_done),
        .o_field_value  (o_field_value),
        .o_read_ok      (o_read_ok),
        .o_bit_position (o_bit_position)
    );

    // shadow of the reader state
    logic [BYTE_W-1:0]  shadow_bytes [STORE_BYTES];
    logic [POS_W-1:0]   rd_pos   = '0;
    logic [SIZE_W-1:0]  buf_size = '0;

    t_field_op          ops_to_send [$];
    t_field_result      results_due [$];
    int unsigned        mismatches  = 0;
    int unsigned        cycle_count = 0;
    logic               item_taken  = 1'b0;

    // bound on the position since the last queued position reset
    int unsigned        reach_bits  = 0;

    // driver pacing
    int unsigned        burst_left  = 5;
    int unsigned        gap_left    = 0;
    bit                 drain_pause = 1'b0;

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    task automatic note_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic push_op(input logic [FUNC_W-1:0] func, input int unsigned addr,
                           input int unsigned data, input int unsigned count);
        t_field_op op;
        op.func  = func;
        op.addr  = addr[BADDR_W-1:0];
        op.data  = data[BYTE_W-1:0];
        op.count = count[COUNT_W-1:0];
        ops_to_send.push_back(op);
    endtask

    // read that keeps every bit it touches inside the preloaded bytes
    task automatic push_bounded_read(input int unsigned addr, input int unsigned data,
                                     input int unsigned count);
        int unsigned span;
        span = (count > MAX_BITS) ? MAX_BITS : count;
        if (reach_bits + span > PRELOAD_BYTES * BITS_PER_BYTE) begin
            push_op(FUNC_RESET_POS, 0, 0, 0);
            reach_bits = 0;
        end
        push_op(FUNC_READ, addr, data, count);
        reach_bits += span;
    endtask

    // nothing queued, nothing held on the item port, nothing outstanding
    task automatic wait_idle();
        do begin
            @(posedge i_clk);
            #1;
        end while (ops_to_send.size() != 0 || start || results_due.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_buffer_size(input int unsigned size);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= size[SIZE_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // expected result of one accepted item; updates the shadow state
    function automatic t_field_result next_field_result(input t_field_op op);
        t_field_result      r;
        int unsigned        eff_size;
        int unsigned        first_byte;
        int unsigned        nbits;
        int unsigned        bit_idx;
        int unsigned        i;
        logic [FIELD_W-1:0] acc;
        logic               bit_val;
        r   = '0;
        acc = '0;
        case (op.func)
            FUNC_WRITE: begin
                shadow_bytes[op.addr] = op.data;
            end
            FUNC_READ: begin
                eff_size   = (buf_size > STORE_BYTES) ? STORE_BYTES : buf_size;
                first_byte = (rd_pos + BITS_PER_BYTE - 1) / BITS_PER_BYTE;
                nbits      = (op.count > MAX_BITS) ? MAX_BITS : op.count;
                // refused once the rounded-up position reaches the buffer end
                if (first_byte < eff_size) begin
                    for (i = 0; i < nbits; i++) begin
                        bit_idx = rd_pos + i;
                        if (bit_idx / BITS_PER_BYTE < eff_size)
                            bit_val = shadow_bytes[bit_idx / BITS_PER_BYTE]
                                          [BITS_PER_BYTE - 1 - bit_idx % BITS_PER_BYTE];
                        else
                            bit_val = 1'b0;
                        acc = {acc[FIELD_W-2:0], bit_val};
                    end
                    rd_pos  = POS_W'(rd_pos + nbits);
                    r.value = acc;
                    r.ok    = 1'b1;
                end
            end
            FUNC_RESET_POS: begin
                rd_pos = '0;
            end
            default: ;
        endcase
        r.pos = rd_pos;
        return r;
    endfunction

    // driver: presents one item per beat, in bursts with gaps between them
    always @(negedge i_clk) begin : drive_items
        logic      present;
        t_field_op op;
        present = start && !item_taken;
        if (i_rst_n && !present) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (drain_pause) begin
                if (results_due.size() == 0)
                    drain_pause = 1'b0;
            end else if (ops_to_send.size() > 0) begin
                op = ops_to_send.pop_front();
                i_func      <= op.func;
                i_byte_addr <= op.addr;
                i_byte_data <= op.data;
                i_bit_count <= op.count;
                present = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left  = $urandom_range(1, 24);
                    gap_left    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    drain_pause = ($urandom_range(0, 31) == 0);
                end
            end
        end
        start <= present;
    end

    // monitor: checks strobed results, predicts accepted items, tracks config
    always @(posedge i_clk) begin : watch_results
        t_field_result want;
        t_field_op     op;
        if (i_rst_n) begin
            if (o_done) begin
                if (results_due.size() == 0) begin
                    note_mismatch("result strobed with none due");
                end else begin
                    want = results_due.pop_front();
                    if (o_field_value !== want.value)
                        note_mismatch($sformatf("field value %h, expected %h",
                                                o_field_value, want.value));
                    if (o_read_ok !== want.ok)
                        note_mismatch($sformatf("read ok %b, expected %b",
                                                o_read_ok, want.ok));
                    if (o_bit_position !== want.pos)
                        note_mismatch($sformatf("bit position %0d, expected %0d",
                                                o_bit_position, want.pos));
                end
            end
            if (start && !busy) begin
                op.func  = i_func;
                op.addr  = i_byte_addr;
                op.data  = i_byte_data;
                op.count = i_bit_count;
                results_due.push_back(next_field_result(op));
            end
            if (i_cfg_valid && o_cfg_ready)
                buf_size = i_cfg_data;
        end
        item_taken <= i_rst_n && start && !busy;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // stimulus
    initial begin
        int unsigned phase_sizes [RANDOM_PHASES];
        int unsigned p;
        int unsigned k;
        int unsigned pick;
        int unsigned cnt;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty buffer: reads refused, then load six bytes
        push_op(FUNC_READ, 0, 0, 32);
        push_op(FUNC_UNUSED, 1, 2, 3);
        push_op(FUNC_WRITE, 0, 8'hFF, 0);
        push_op(FUNC_WRITE, 1, 8'h00, 0);
        push_op(FUNC_WRITE, 2, 8'hA5, 0);
        push_op(FUNC_WRITE, 3, 8'h5A, 0);
        push_op(FUNC_WRITE, 4, 8'h80, 0);
        push_op(FUNC_WRITE, 5, 8'h01, 0);
        push_op(FUNC_RESET_POS, 0, 0, 0);
        wait_idle();
        write_buffer_size(6);

        // zero count, aligned and unaligned fields, field running past the end,
        // refused read, oversized counts, top address write
        push_op(FUNC_READ, 0, 0, 0);
        push_op(FUNC_READ, 0, 0, 32);
        push_op(FUNC_READ, 0, 0, 3);
        push_op(FUNC_READ, 0, 0, 32);
        push_op(FUNC_READ, 0, 0, 63);
        push_op(FUNC_UNUSED, 4095, 255, 63);
        push_op(FUNC_RESET_POS, 0, 0, 0);
        push_op(FUNC_READ, 0, 0, 33);
        push_op(FUNC_READ, 0, 0, 7);
        push_op(FUNC_READ, 0, 0, 1);
        push_op(FUNC_WRITE, 4095, 8'h3C, 0);
        push_op(FUNC_READ, 0, 0, 8);
        wait_idle();

        // load the start of the store; bounded reads stay inside it
        for (k = 0; k < PRELOAD_BYTES; k++)
            push_op(FUNC_WRITE, k, $urandom_range(0, 255), 0);
        wait_idle();

        // full-size buffer, wide fields from the start
        write_buffer_size(STORE_BYTES);
        push_op(FUNC_RESET_POS, 0, 0, 0);
        reach_bits = 0;
        for (k = 0; k < SWEEP_READS; k++)
            push_bounded_read(0, 0, $urandom_range(24, 32));
        wait_idle();

        // random phases over a spread of buffer sizes
        phase_sizes[0] = 0;
        phase_sizes[1] = 1;
        phase_sizes[2] = (1 << SIZE_W) - 1;
        phase_sizes[3] = STORE_BYTES + 1;
        phase_sizes[4] = $urandom_range(2, 8);
        phase_sizes[5] = $urandom_range(2, 8);
        phase_sizes[6] = $urandom_range(9, 40);
        phase_sizes[7] = $urandom_range(9, 40);
        phase_sizes[8] = $urandom_range(41, 600);
        phase_sizes[9] = $urandom_range(2, 16);
        for (p = 0; p < RANDOM_PHASES; p++) begin
            write_buffer_size(phase_sizes[p]);
            for (k = 0; k < PHASE_OPS; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(33, 63)
                                                      : $urandom_range(0, 32);
                    push_bounded_read($urandom_range(0, STORE_BYTES - 1),
                                      $urandom_range(0, 255), cnt);
                end else if (pick < 80) begin
                    // half the writes land where small buffers are read
                    push_op(FUNC_WRITE,
                            ($urandom_range(0, 1) == 0) ? $urandom_range(0, 47)
                                                        : $urandom_range(0, STORE_BYTES - 1),
                            $urandom_range(0, 255), $urandom_range(0, 63));
                end else if (pick < 90) begin
                    push_op(FUNC_RESET_POS, $urandom_range(0, STORE_BYTES - 1),
                            $urandom_range(0, 255), $urandom_range(0, 63));
                    reach_bits = 0;
                end else begin
                    push_op(FUNC_UNUSED, $urandom_range(0, STORE_BYTES - 1),
                            $urandom_range(0, 255), $urandom_range(0, 63));
                end
            end
            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        if (results_due.size() != 0)
            note_mismatch($sformatf("%0d results never strobed", results_due.size()));
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
